/* hw/rtl/amt_pkg.sv */
`default_nettype none
package amt_pkg;

    // Width of every numeric field on the channels
    localparam int FIELD_W = 32;

    // Operation codes
    localparam logic [2:0] OP_WR_CUR  = 3'd0;
    localparam logic [2:0] OP_WR_OPND = 3'd1;
    localparam logic [2:0] OP_IDENT   = 3'd2;
    localparam logic [2:0] OP_COMPOSE = 3'd3;
    localparam logic [2:0] OP_XFORM   = 3'd4;
    localparam logic [2:0] OP_READ    = 3'd5;

    // Commands from the sequencer to the datapath
    typedef struct packed {
        logic       accept;   // input word taken this cycle
        logic       mul;      // issue one product
        logic       fin;      // round, clamp and store one element
        logic       load;     // move the result into the output registers
        logic       compose;  // matrix product rather than vertex transform
        logic [3:0] elem;     // element being computed
        logic [1:0] term;     // term of the dot product
    } amt_cmd_t;

endpackage
`default_nettype wire

/* hw/rtl/amt_in_if.sv */
`default_nettype none
interface amt_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [1:0]  row;
    logic [1:0]  col;
    logic signed [31:0] value;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;

    modport source (output valid, opcode, row, col, value, vx, vy, vz, input ready);
    modport sink   (input valid, opcode, row, col, value, vx, vy, vz, output ready);
endinterface
`default_nettype wire

/* hw/rtl/amt_out_if.sv */
`default_nettype none
interface amt_out_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] read_value;
    logic        saturated;

    modport source (output valid, out_x, out_y, out_z, read_value, saturated, input ready);
    modport sink   (input valid, out_x, out_y, out_z, read_value, saturated, output ready);
endinterface
`default_nettype wire

/* hw/rtl/affine_matrix_transform_unit_top.sv */
`default_nettype none
// Affine 4x4 matrix unit: element write, identity, compose, read, vertex transform.
// A read is accepted and then loaded into the output registers. A transform runs each of the
// 3 columns on one shared multiplier (the products, a drain, a finish), then a load.
// One word at a time: a new word is accepted only when idle, so a read, transform or compose
// finishes first; compose (16 elements) loads no output; a waiting result holds the load.
// Reset (rst_n, asynchronous, active low) clears both matrices and the control state.
module affine_matrix_transform_unit_top #(
    parameter int FRAC_BITS = 16,
    parameter int WORD_BITS = 32
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    amt_in_if.sink     in_ch,
    amt_out_if.source  out_ch
);
    import amt_pkg::*;

    amt_cmd_t cmd;

    amt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .opcode    (in_ch.opcode),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd)
    );

    amt_dp #(
        .FRAC_BITS (FRAC_BITS),
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .opcode     (in_ch.opcode),
        .row        (in_ch.row),
        .col        (in_ch.col),
        .value      (in_ch.value),
        .vx         (in_ch.vx),
        .vy         (in_ch.vy),
        .vz         (in_ch.vz),
        .out_x      (out_ch.out_x),
        .out_y      (out_ch.out_y),
        .out_z      (out_ch.out_z),
        .read_value (out_ch.read_value),
        .saturated  (out_ch.saturated)
    );

endmodule
`default_nettype wire

/* hw/rtl/amt_ctrl.sv */
`default_nettype none
module amt_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire logic [2:0]      opcode,
    output logic                 in_ready,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output amt_pkg::amt_cmd_t    cmd
);
    import amt_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RUN   = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_FIN   = 3'd3;
    localparam logic [2:0] S_LOAD  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [3:0] elem_reg, elem_next;
    logic [1:0] term_reg, term_next;
    logic       comp_reg, comp_next;
    logic       ovalid_reg, ovalid_next;
    logic       take;
    logic [1:0] last_term;
    logic [3:0] last_elem;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ovalid_reg;
    assign take      = in_valid && in_ready;
    assign last_term = comp_reg ? 2'd3 : 2'd2;
    assign last_elem = comp_reg ? 4'd15 : 4'd2;

    // Sequence the dot products
    always_comb
    begin
        state_next  = state_reg;
        elem_next   = elem_reg;
        term_next   = term_reg;
        comp_next   = comp_reg;
        ovalid_next = ovalid_reg && !out_ready;
        cmd         = '0;
        cmd.compose = comp_reg;
        cmd.elem    = elem_reg;
        cmd.term    = term_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.accept = take;
                if (take)
                begin
                    elem_next = 4'd0;
                    term_next = 2'd0;
                    comp_next = (opcode == OP_COMPOSE);
                    if (opcode == OP_COMPOSE || opcode == OP_XFORM)
                    begin
                        state_next = S_RUN;
                    end
                    else if (opcode == OP_READ)
                    begin
                        state_next = S_LOAD;
                    end
                end
            end
            S_RUN:
            begin
                cmd.mul = 1'b1;
                if (term_reg == last_term)
                begin
                    term_next  = 2'd0;
                    state_next = S_DRAIN;
                end
                else
                begin
                    term_next = term_reg + 2'd1;
                end
            end
            S_DRAIN:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.fin = 1'b1;
                if (elem_reg == last_elem)
                begin
                    state_next = comp_reg ? S_IDLE : S_LOAD;
                end
                else
                begin
                    elem_next  = elem_reg + 4'd1;
                    state_next = S_RUN;
                end
            end
            S_LOAD:
            begin
                if (!ovalid_reg || out_ready)
                begin
                    cmd.load    = 1'b1;
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            elem_reg   <= 4'd0;
            term_reg   <= 2'd0;
            comp_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            elem_reg   <= elem_next;
            term_reg   <= term_next;
            comp_reg   <= comp_next;
            ovalid_reg <= ovalid_next;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/amt_dp.sv */
`default_nettype none
module amt_dp #(
    parameter int FRAC_BITS = 16,
    parameter int WORD_BITS = 32
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire amt_pkg::amt_cmd_t           cmd,
    input  wire logic [2:0]                  opcode,
    input  wire logic [1:0]                  row,
    input  wire logic [1:0]                  col,
    input  wire logic signed [amt_pkg::FIELD_W-1:0] value,
    input  wire logic signed [amt_pkg::FIELD_W-1:0] vx,
    input  wire logic signed [amt_pkg::FIELD_W-1:0] vy,
    input  wire logic signed [amt_pkg::FIELD_W-1:0] vz,
    output logic signed [amt_pkg::FIELD_W-1:0] out_x,
    output logic signed [amt_pkg::FIELD_W-1:0] out_y,
    output logic signed [amt_pkg::FIELD_W-1:0] out_z,
    output logic signed [amt_pkg::FIELD_W-1:0] read_value,
    output logic                             saturated
);
    import amt_pkg::*;

    localparam int W     = WORD_BITS;
    localparam int PW    = 2 * W;
    localparam int ACC_W = 2 * W + 3;
    localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] ONE_VAL =
        (FRAC_BITS <= W - 2) ? (W'(1) << FRAC_BITS) : WMAX;
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);

    logic signed [W-1:0]     cur_reg  [16];
    logic signed [W-1:0]     opnd_reg [16];
    logic signed [W-1:0]     vtx_reg  [3];
    logic signed [W-1:0]     rbuf_reg [4];
    logic signed [W-1:0]     res_reg  [3];
    logic [3:0]              idx_reg;
    logic                    rd_reg;
    logic                    sat_reg;
    logic signed [PW-1:0]    prod_reg;
    logic                    pvld_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [W-1:0]     ox_reg, oy_reg, oz_reg, rv_reg;
    logic                    osat_reg;

    logic [3:0]              cur_addr;
    logic [3:0]              opnd_addr;
    logic signed [W-1:0]     cur_rd;
    logic signed [W-1:0]     op_a, op_b;
    logic [1:0]              erow, ecol;
    logic signed [ACC_W-1:0] rnd, total;
    logic signed [W-1:0]     clamped;
    logic                    hit;

    assign erow = cmd.elem[3:2];
    assign ecol = cmd.compose ? cmd.elem[1:0] : cmd.elem[1:0];

    // Single read address into the current matrix
    always_comb
    begin
        if (cmd.load)
        begin
            cur_addr = idx_reg;
        end
        else if (cmd.fin)
        begin
            cur_addr = {2'd3, ecol};
        end
        else if (cmd.compose)
        begin
            cur_addr = {erow, cmd.term};
        end
        else
        begin
            cur_addr = {cmd.term, ecol};
        end
    end

    assign opnd_addr = {cmd.term, ecol};
    assign cur_rd    = cur_reg[cur_addr];
    assign op_a      = cmd.compose ? cur_rd : vtx_reg[cmd.term];
    assign op_b      = cmd.compose ? opnd_reg[opnd_addr] : cur_rd;

    // Round half up, add the translation term for a vertex transform, clamp
    always_comb
    begin
        rnd   = (acc_reg + HALF) >>> FRAC_BITS;
        total = cmd.compose ? rnd : rnd + ACC_W'(cur_rd);
        hit   = 1'b0;
        if (total > ACC_W'(WMAX))
        begin
            clamped = WMAX;
            hit     = 1'b1;
        end
        else if (total < ACC_W'(WMIN))
        begin
            clamped = WMIN;
            hit     = 1'b1;
        end
        else
        begin
            clamped = total[W-1:0];
        end
    end

    // Multiply and accumulate
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pvld_reg <= 1'b0;
            acc_reg  <= '0;
        end
        else
        begin
            pvld_reg <= cmd.mul;
            if (cmd.fin)
            begin
                acc_reg <= '0;
            end
            else if (pvld_reg)
            begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            prod_reg <= PW'(op_a) * PW'(op_b);
        end
    end

    // Matrix storage: element writes, identity and composed rows
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
            begin
                cur_reg[i]  <= '0;
                opnd_reg[i] <= '0;
            end
        end
        else if (cmd.accept)
        begin
            case (opcode)
                OP_WR_CUR:  cur_reg[{row, col}]  <= value[W-1:0];
                OP_WR_OPND: opnd_reg[{row, col}] <= value[W-1:0];
                OP_IDENT:
                begin
                    for (int i = 0; i < 16; i++)
                    begin
                        cur_reg[i] <= ((i / 4) == (i % 4)) ? ONE_VAL : '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (cmd.fin && cmd.compose && ecol == 2'd3)
        begin
            for (int j = 0; j < 3; j++)
            begin
                cur_reg[{erow, 2'(j)}] <= rbuf_reg[j];
            end
            cur_reg[{erow, 2'd3}] <= clamped;
        end
    end

    // Capture operands, collect results
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            vtx_reg[0] <= vx[W-1:0];
            vtx_reg[1] <= vy[W-1:0];
            vtx_reg[2] <= vz[W-1:0];
            idx_reg    <= {row, col};
            rd_reg     <= (opcode == OP_READ);
            sat_reg    <= 1'b0;
        end
        if (cmd.fin)
        begin
            if (cmd.compose)
            begin
                rbuf_reg[ecol] <= clamped;
            end
            else
            begin
                res_reg[ecol] <= clamped;
                sat_reg       <= sat_reg | hit;
            end
        end
        // Load either the element read or the transformed vertex
        if (cmd.load)
        begin
            if (rd_reg)
            begin
                ox_reg   <= '0;
                oy_reg   <= '0;
                oz_reg   <= '0;
                osat_reg <= 1'b0;
                rv_reg   <= cur_rd;
            end
            else
            begin
                ox_reg   <= res_reg[0];
                oy_reg   <= res_reg[1];
                oz_reg   <= res_reg[2];
                osat_reg <= sat_reg;
                rv_reg   <= '0;
            end
        end
    end

    assign out_x      = FIELD_W'(ox_reg);
    assign out_y      = FIELD_W'(oy_reg);
    assign out_z      = FIELD_W'(oz_reg);
    assign read_value = FIELD_W'(rv_reg);
    assign saturated  = osat_reg;

endmodule
`default_nettype wire
